// ===== src/crsf_pkg.sv =====
// Shared constants, codes and the CRC-8 update for the CRSF frame receiver.
`timescale 1ns / 1ps

package crsf_pkg;

    // Default build constants
    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int CHANNEL_COUNT_DEF   = 16;
    localparam int CHANNEL_BITS_DEF    = 11;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 4;
    localparam int VALUE_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CH_BITS_MAX = 16;

    // Frame layout
    localparam int HEAD_GUESS = 5;
    localparam int PAYLOAD_AT = 3;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1100;
    localparam logic [BYTE_W-1:0]    RC_TYPE_RST = 8'd22;
    localparam logic [BYTE_W-1:0]    FC_ADDR_RST = 8'd200;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RC_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FC_ADDR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_RC      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd3;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;

    // One byte of CRC-8 DVB-S2, MSB first
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/crsf_frame_receiver.sv =====
// CRSF frame receiver: byte framing, CRC-8 check and RC channel unpacking.
// A byte waits in the input register; its first result is loaded into the output register.
// Throughput: one byte per cycle unless stalled; framing and CRC update run in one pass
// per byte. An RC frame gives CHANNEL_COUNT results from the output buffer, one per cycle
// when not stalled; input stalls only while a result-bearing byte waits for it to drain.
// Reset: synchronous, active low; clears framing state and loads register defaults.
`timescale 1ns / 1ps

module crsf_frame_receiver #(
    parameter int MAX_FRAME_BYTES = crsf_pkg::MAX_FRAME_BYTES_DEF,
    parameter int CHANNEL_COUNT   = crsf_pkg::CHANNEL_COUNT_DEF,
    parameter int CHANNEL_BITS    = crsf_pkg::CHANNEL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [crsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // byte input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [crsf_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic [crsf_pkg::TIME_W-1:0]     i_time_us,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [crsf_pkg::STATUS_W-1:0]   o_status,
    output logic [crsf_pkg::BYTE_W-1:0]     o_frame_type,
    output logic [crsf_pkg::INDEX_W-1:0]    o_channel_index,
    output logic [crsf_pkg::VALUE_W-1:0]    o_channel_value,
    output logic                            o_last
);
    import crsf_pkg::*;

    localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int NEED   = (CHANNEL_COUNT * CHANNEL_BITS + 7) / 8;
    localparam int PAY_W  = NEED * BYTE_W;
    localparam int CH_W   = CHANNEL_COUNT * CHANNEL_BITS;
    localparam int FULL_W = BYTE_W + 1;

    // configuration registers
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [BYTE_W-1:0]    r_rc_type;
    logic [BYTE_W-1:0]    r_fc_addr;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [TIME_W-1:0] r_in_time;

    // framing state
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [TIME_W-1:0] r_start, n_start;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [BYTE_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [PAY_W-1:0]  r_pay, n_pay;

    // output buffer
    logic                r_out_valid;
    logic                r_out_burst;
    logic [STATUS_W-1:0] r_out_status;
    logic [BYTE_W-1:0]   r_out_type;
    logic [INDEX_W-1:0]  r_out_idx;
    logic [CH_W-1:0]     r_out_chans;

    // per-byte evaluation
    logic                res_valid;
    logic                res_burst;
    logic [STATUS_W-1:0] res_status;
    logic [BYTE_W-1:0]   res_type;
    logic                out_last;
    logic                out_free;
    logic                proc_take;
    logic [TIME_W-1:0]   gap;
    logic                timed_out;
    logic [POS_W-1:0]    pos0, pos1, pay_off;
    logic [FULL_W-1:0]   full_len;
    logic [CH_BITS_MAX-1:0] chan_wide;

    assign gap       = r_in_time - r_start;
    assign timed_out = !gap[TIME_W-1] && (gap > TIME_W'(r_timeout));
    assign pos0      = timed_out ? '0 : r_pos;
    assign pos1      = pos0 + POS_W'(1);
    assign pay_off   = pos0 - POS_W'(PAYLOAD_AT);
    assign full_len  = FULL_W'(r_len) + FULL_W'(2);

    always_comb begin
        n_pos      = r_pos;
        n_start    = r_start;
        n_crc      = r_crc;
        n_addr     = r_addr;
        n_len      = r_len;
        n_type     = r_type;
        n_pay      = r_pay;
        res_valid  = 1'b0;
        res_burst  = 1'b0;
        res_status = ST_RC;
        res_type   = r_type;

        if (pos0 == '0) begin
            n_start = r_in_time;
        end

        if ((pos0 >= POS_W'(PAYLOAD_AT) && FULL_W'(pos0) >= full_len) ||
            FULL_W'(pos0) >= FULL_W'(MAX_FRAME_BYTES)) begin
            // overrun: drop silently
            n_pos = '0;
        end else begin
            n_pos = pos1;
            if (pos0 == POS_W'(0)) begin
                n_addr = r_in_byte;
            end else if (pos0 == POS_W'(1)) begin
                n_len = r_in_byte;
            end else if (pos0 == POS_W'(2)) begin
                n_type = r_in_byte;
            end else begin
                for (int j = 0; j < NEED; j++) begin
                    if (pay_off == POS_W'(j)) begin
                        n_pay[j*BYTE_W +: BYTE_W] = r_in_byte;
                    end
                end
            end

            if (pos1 == POS_W'(2)) begin
                if (r_in_byte < BYTE_W'(2) ||
                    FULL_W'(r_in_byte) > FULL_W'(MAX_FRAME_BYTES - 2)) begin
                    n_pos      = '0;
                    res_valid  = 1'b1;
                    res_status = ST_LEN_ERR;
                    res_type   = '0;
                end
            end else if (pos1 < POS_W'(PAYLOAD_AT) || FULL_W'(pos1) < full_len) begin
                if (pos1 >= POS_W'(PAYLOAD_AT)) begin
                    n_crc = crc8_step((pos1 == POS_W'(PAYLOAD_AT)) ? '0 : r_crc,
                                      r_in_byte);
                end
            end else begin
                // frame complete: this byte is the CRC
                n_pos     = '0;
                res_valid = 1'b1;
                res_type  = r_type;
                if (r_crc != r_in_byte) begin
                    res_status = ST_CRC_ERR;
                end else if (r_type != r_rc_type || r_addr != r_fc_addr) begin
                    res_status = ST_IGNORED;
                end else if (FULL_W'(r_len) < FULL_W'(NEED + 2)) begin
                    res_status = ST_LEN_ERR;
                end else begin
                    res_status = ST_RC;
                    res_burst  = 1'b1;
                end
            end
        end
    end

    assign out_last  = !r_out_burst || (r_out_idx == INDEX_W'(CHANNEL_COUNT - 1));
    assign out_free  = !r_out_valid || (!i_out_stall && out_last);
    assign proc_take = r_in_valid && (out_free || !res_valid);
    assign o_in_stall = r_in_valid && !proc_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_rc_type   <= RC_TYPE_RST;
            r_fc_addr   <= FC_ADDR_RST;
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_start     <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
            r_out_burst <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                    CFG_RC_TYPE: r_rc_type <= i_cfg_data[BYTE_W-1:0];
                    CFG_FC_ADDR: r_fc_addr <= i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end

            // input register: take a new item whenever it is empty or the held one moves on
            if (!r_in_valid || proc_take) begin
                r_in_valid <= i_in_valid;
            end

            if (proc_take) begin
                r_pos   <= n_pos;
                r_start <= n_start;
                r_crc   <= n_crc;
            end

            // output buffer: advance through channels, reload on a new result
            if (proc_take && res_valid) begin
                r_out_valid <= 1'b1;
                r_out_burst <= res_burst;
            end else if (r_out_valid && !i_out_stall && out_last) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || proc_take) begin
            r_in_byte <= i_rx_byte;
            r_in_time <= i_time_us;
        end
        if (proc_take) begin
            r_addr <= n_addr;
            r_len  <= n_len;
            r_type <= n_type;
            r_pay  <= n_pay;
        end
        if (proc_take && res_valid) begin
            r_out_status <= res_status;
            r_out_type   <= res_type;
            r_out_idx    <= '0;
            r_out_chans  <= n_pay[CH_W-1:0];
        end else if (r_out_valid && !i_out_stall && !out_last) begin
            r_out_idx   <= r_out_idx + INDEX_W'(1);
            r_out_chans <= r_out_chans >> CHANNEL_BITS;
        end
    end

    assign chan_wide       = CH_BITS_MAX'(r_out_chans[CHANNEL_BITS-1:0]);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_frame_type    = r_out_type;
    assign o_channel_index = r_out_burst ? r_out_idx : '0;
    assign o_channel_value = r_out_burst ? chan_wide[VALUE_W-1:0] : '0;
    assign o_last          = out_last;

endmodule
